// ===== rtl/pmsc_pkg.sv =====
// Shared types, widths and register codes for the point-mass safety controller.
// Used by every module of the block; depends on nothing.
`default_nettype none

package pmsc_pkg;

  // Number of axes evaluated; lanes beyond this one read as zero.
  localparam int AXES     = 3;
  localparam int MAX_AXES = 3;

  localparam int FW      = 16;  // Q8.8 fields and packed lanes
  localparam int DW      = 18;  // v -/+ vr
  localparam int SQ_W    = 36;  // squares and the parabola numerator
  localparam int VR2_W   = 34;  // 2 * vr^2
  localparam int SL_W    = 35;  // (v -/+ vr) * R
  localparam int PR_W    = 53;  // numerator * R
  localparam int ACC_W   = 40;  // surfaces A and B at full width
  localparam int VAL_W   = 32;  // Q16.16 outputs
  localparam int PRIO_W  = 17;  // Q0.16 priority with room for one
  localparam int CFG_W   = 48;
  localparam int CFG_AW  = 3;
  localparam int IN_W    = 96;
  localparam int OUT_W   = 200;

  localparam int LANE_STAGES  = 6;
  localparam int MERGE_STAGES = 3;
  localparam int PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;

  localparam logic [PRIO_W-1:0] PRIO_ONE = PRIO_W'(65536);
  localparam logic [1:0]        GPOS_NEG = 2'b11;
  localparam logic [1:0]        GPOS_POS = 2'b01;

  typedef enum logic [CFG_AW-1:0] {
    REG_REF_SPEED   = 3'd0,
    REG_ACCEL_RECIP = 3'd1,
    REG_EXPANSION   = 3'd2,
    REG_SPEEDUP     = 3'd3,
    REG_BRAKE       = 3'd4,
    REG_PRIO_LOW    = 3'd5,
    REG_PRIO_SCALE  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [FW-1:0] vr;
    logic [FW-1:0] recip;
    logic [FW-1:0] xe;
    logic [FW-1:0] u_acc;
    logic [FW-1:0] u_dec;
  } lane_cfg_t;

  typedef struct packed {
    logic [LANE_STAGES-1:0] en;
  } lane_ctl_t;

  typedef struct packed {
    logic [MERGE_STAGES-1:0] en;
  } merge_ctl_t;

  typedef struct packed {
    logic [ACC_W-1:0] m;
    logic [1:0]       gpos;
    logic [FW-1:0]    ctrl;
    logic [VAL_W-1:0] slope;
  } lane_res_t;

  typedef struct packed {
    logic [1:0]       gpos;
    logic [FW-1:0]    ctrl;
    logic [VAL_W-1:0] slope;
  } axis_out_t;

endpackage

`default_nettype wire

// ===== rtl/pmsc_lane.sv =====
// One axis lane: six-stage pipeline computing surfaces A and B, the gradient and the control.
// Depends on pmsc_pkg.
`default_nettype none

module pmsc_lane
  import pmsc_pkg::*;
(
  input  logic                 clk,
  input  lane_ctl_t            ctl,
  input  lane_cfg_t            cfg,
  input  logic signed [FW-1:0] pos,
  input  logic signed [FW-1:0] vel,
  output lane_res_t            res
);

  logic signed [DW-1:0]    vel_ext;
  logic signed [DW-1:0]    vr_ext;
  logic signed [FW:0]      r_s;
  logic [2*FW-1:0]         vr_sq;

  logic signed [FW-1:0]    x1, x2, x3, x4;
  logic signed [DW-1:0]    da1, db1;
  logic signed [SQ_W-1:0]  sqa2, sqb2;
  logic [VR2_W-1:0]        vr2_2;
  logic signed [SL_W-1:0]  sla2, slb2, sla3, slb3, sla4, slb4, sla5, slb5;
  logic signed [SQ_W-1:0]  na3, nb3;
  logic signed [PR_W-1:0]  prod_a, prod_b;
  logic signed [ACC_W-1:0] qa4, qb4;
  logic signed [DW-1:0]    off;
  logic signed [ACC_W-1:0] off_sh;
  logic signed [ACC_W-1:0] va5, vb5;
  logic                    xneg5;
  logic                    gt;

  assign vel_ext = {{(DW-FW){vel[FW-1]}}, vel};
  assign vr_ext  = $signed({{(DW-FW){1'b0}}, cfg.vr});
  assign r_s     = $signed({1'b0, cfg.recip});
  assign vr_sq   = cfg.vr * cfg.vr;

  // Stage 1: shifted velocities.
  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      x1  <= pos;
      da1 <= vel_ext - vr_ext;
      db1 <= vel_ext + vr_ext;
    end
  end

  // Stage 2: squares and the velocity slopes.
  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      x2    <= x1;
      sqa2  <= da1 * da1;
      sqb2  <= db1 * db1;
      vr2_2 <= {1'b0, vr_sq, 1'b0};
      sla2  <= da1 * r_s;
      slb2  <= db1 * r_s;
    end
  end

  // Stage 3: parabola numerators, twice the Q16.16 value.
  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      x3   <= x2;
      na3  <= sqa2 - $signed({{(SQ_W-VR2_W){1'b0}}, vr2_2});
      nb3  <= sqb2 - $signed({{(SQ_W-VR2_W){1'b0}}, vr2_2});
      sla3 <= sla2;
      slb3 <= slb2;
    end
  end

  // Stage 4: scale by R; dropping 13 bits is a floor shift to Q16.16.
  assign prod_a = na3 * r_s;
  assign prod_b = nb3 * r_s;

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      x4   <= x3;
      qa4  <= prod_a[PR_W-1:13];
      qb4  <= prod_b[PR_W-1:13];
      sla4 <= sla3;
      slb4 <= slb3;
    end
  end

  // Stage 5: subtract the position offset (x + xe) from surface A and add it to surface B, in Q16.16.
  assign off    = $signed({{(DW-FW){x4[FW-1]}}, x4}) + $signed({{(DW-FW){1'b0}}, cfg.xe});
  assign off_sh = {{(ACC_W-DW-8){off[DW-1]}}, off, 8'b0};

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      va5   <= qa4 - off_sh;
      vb5   <= qb4 + off_sh;
      sla5  <= sla4;
      slb5  <= slb4;
      xneg5 <= x4[FW-1];
    end
  end

  // Stage 6: pick the active surface, its slope and the outside-rule control.
  assign gt = va5 > vb5;

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      res.m <= gt ? va5 : vb5;
      if (gt) begin
        res.gpos  <= GPOS_NEG;
        res.slope <= {{(VAL_W-SL_W+4){sla5[SL_W-1]}}, sla5[SL_W-1:4]};
      end else begin
        res.gpos  <= GPOS_POS;
        res.slope <= {{(VAL_W-SL_W+4){slb5[SL_W-1]}}, slb5[SL_W-1:4]};
      end
      if (!xneg5) begin
        res.ctrl <= va5[ACC_W-1] ? cfg.u_dec : cfg.u_acc;
      end else begin
        res.ctrl <= vb5[ACC_W-1] ? cfg.u_acc : cfg.u_dec;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pmsc_merge.sv =====
// Merging stages: maximum over the lanes, saturation, and the priority mapping.
// Depends on pmsc_pkg; fed by the pmsc_lane outputs.
`default_nettype none

module pmsc_merge
  import pmsc_pkg::*;
(
  input  logic                    clk,
  input  merge_ctl_t              ctl,
  input  lane_res_t [MAX_AXES-1:0] lanes,
  input  logic [VAL_W-1:0]        prio_low,
  input  logic [VAL_W-1:0]        prio_scale,
  output logic [VAL_W-1:0]        value,
  output axis_out_t [MAX_AXES-1:0] axes,
  output logic [PRIO_W-1:0]       prio
);

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sh7FFFFFFF);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sh80000000);

  logic signed [ACC_W-1:0] best;
  logic [VAL_W-1:0]        val_sat;
  axis_out_t [MAX_AXES-1:0] axes_sel;
  logic [VAL_W-1:0]        val1, val2;
  axis_out_t [MAX_AXES-1:0] axes1, axes2;
  logic signed [VAL_W:0]   diff;
  logic [VAL_W-1:0]        d2;
  logic                    dpos2;
  logic [2*VAL_W-1:0]      prod;
  logic [2*VAL_W-17:0]     frac;
  logic [PRIO_W-1:0]       frac_cl;

  always_comb begin
    best = '0;
    for (int i = 0; i < MAX_AXES; i++) begin
      axes_sel[i] = '0;
      if (i < AXES) begin
        axes_sel[i] = '{gpos: lanes[i].gpos, ctrl: lanes[i].ctrl, slope: lanes[i].slope};
        if (i == 0 || $signed(lanes[i].m) > best) begin
          best = $signed(lanes[i].m);
        end
      end
    end
    if (best > SAT_MAX) begin
      val_sat = VAL_W'(SAT_MAX);
    end else if (best < SAT_MIN) begin
      val_sat = VAL_W'(SAT_MIN);
    end else begin
      val_sat = best[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      val1  <= val_sat;
      axes1 <= axes_sel;
    end
  end

  // Distance above the threshold; only a positive distance lowers the priority.
  assign diff = $signed({val1[VAL_W-1], val1}) - $signed({prio_low[VAL_W-1], prio_low});

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      val2  <= val1;
      axes2 <= axes1;
      d2    <= diff[VAL_W-1:0];
      dpos2 <= !diff[VAL_W] && (diff[VAL_W-1:0] != '0);
    end
  end

  assign prod    = {{VAL_W{1'b0}}, d2} * {{VAL_W{1'b0}}, prio_scale};
  assign frac    = prod[2*VAL_W-1:16];
  assign frac_cl = (frac > (2*VAL_W-16)'(PRIO_ONE)) ? PRIO_ONE : frac[PRIO_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      value <= val2;
      axes  <= axes2;
      prio  <= dpos2 ? (PRIO_ONE - frac_cl) : PRIO_ONE;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/point_mass_safety_controller.sv =====
// Top level of the point-mass safety controller: ports, configuration registers,
// pipeline flow control, three pmsc_lane instances and pmsc_merge. Depends on pmsc_pkg.
//
// Usage: software writes the seven configuration registers through cfg_we, cfg_addr
// and cfg_data while the block is idle. Register 0 holds the three Q8.8 reference
// speeds, 1 the Q4.12 acceleration reciprocals, 2 the position expansions, 3 and 4
// the speed-up and brake control words, 5 the priority threshold and 6 the priority
// scale. A write to an address past the list is dropped.
// Each transaction on the s_ channel carries one state (three positions, three
// velocities); each transaction on the m_ channel returns one result: the safety
// value, per-axis controls and gradients, and the priority.
// An accepted input reaches m_tvalid through six stages in each axis lane (offsets,
// squares, numerators, scaling, position offset, selection) and three merging stages
// (maximum, threshold distance, priority multiply). The three lanes run side by side,
// so one transaction is taken every cycle unless the receiver stalls the full pipeline.
// Reset clears all valid flags and loads the register reset values; payload registers
// are not reset. When the receiver holds m_tready low, the result stays on m_tdata and
// bubbles in the pipeline are squeezed out first; only a completely full pipeline
// drops s_tready.
`default_nettype none

module point_mass_safety_controller
  import pmsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (16 bits each)
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // safety_value[31:0], ctrl_x, ctrl_y, ctrl_z (16 each), grad_pos_x/y/z (2 each),
  // grad_vel_x/y/z (32 each), priority_res (17), one zero pad bit
  output logic [OUT_W-1:0]  m_tdata,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic [CFG_W-1:0] ref_speed_pack;
  logic [CFG_W-1:0] accel_recip_pack;
  logic [CFG_W-1:0] expansion_pack;
  logic [CFG_W-1:0] speedup_ctrl_pack;
  logic [CFG_W-1:0] brake_ctrl_pack;
  logic [VAL_W-1:0] prio_low;
  logic [VAL_W-1:0] prio_scale;

  logic [PIPE_STAGES-1:0] valid;
  logic [PIPE_STAGES-1:0] en;
  lane_ctl_t              lane_ctl;
  merge_ctl_t             merge_ctl;

  lane_res_t [MAX_AXES-1:0] lane_res;
  axis_out_t [MAX_AXES-1:0] axes;
  logic [VAL_W-1:0]         value;
  logic [PRIO_W-1:0]        prio;

  // Configuration registers. Writes must arrive only while no transaction is in flight (the
  // block does not enforce this), since the lanes read these directly at every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_speed_pack    <= '0;
      accel_recip_pack  <= '0;
      expansion_pack    <= '0;
      speedup_ctrl_pack <= '0;
      brake_ctrl_pack   <= '0;
      prio_low          <= '0;
      prio_scale        <= VAL_W'(65536);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_REF_SPEED:   ref_speed_pack    <= cfg_data;
        REG_ACCEL_RECIP: accel_recip_pack  <= cfg_data;
        REG_EXPANSION:   expansion_pack    <= cfg_data;
        REG_SPEEDUP:     speedup_ctrl_pack <= cfg_data;
        REG_BRAKE:       brake_ctrl_pack   <= cfg_data;
        REG_PRIO_LOW:    prio_low          <= cfg_data[VAL_W-1:0];
        REG_PRIO_SCALE:  prio_scale        <= cfg_data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    en[PIPE_STAGES-1] = !valid[PIPE_STAGES-1] || m_tready;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign lane_ctl.en  = en[LANE_STAGES-1:0];
  assign merge_ctl.en = en[PIPE_STAGES-1:LANE_STAGES];
  assign s_tready     = en[0];
  assign m_tvalid     = valid[PIPE_STAGES-1];

  for (genvar i = 0; i < MAX_AXES; i++) begin : g_lane
    if (i < AXES) begin : g_used
      lane_cfg_t lcfg;

      assign lcfg.vr    = ref_speed_pack[FW*i +: FW];
      assign lcfg.recip = accel_recip_pack[FW*i +: FW];
      assign lcfg.xe    = expansion_pack[FW*i +: FW];
      assign lcfg.u_acc = speedup_ctrl_pack[FW*i +: FW];
      assign lcfg.u_dec = brake_ctrl_pack[FW*i +: FW];

      pmsc_lane u_lane (
        .clk (clk),
        .ctl (lane_ctl),
        .cfg (lcfg),
        .pos ($signed(s_tdata[FW*i +: FW])),
        .vel ($signed(s_tdata[FW*(i+3) +: FW])),
        .res (lane_res[i])
      );
    end else begin : g_unused
      assign lane_res[i] = '0;
    end
  end

  pmsc_merge u_merge (
    .clk        (clk),
    .ctl        (merge_ctl),
    .lanes      (lane_res),
    .prio_low   (prio_low),
    .prio_scale (prio_scale),
    .value      (value),
    .axes       (axes),
    .prio       (prio)
  );

  assign m_tdata = {1'b0, prio,
                    axes[2].slope, axes[1].slope, axes[0].slope,
                    axes[2].gpos, axes[1].gpos, axes[0].gpos,
                    axes[2].ctrl, axes[1].ctrl, axes[0].ctrl,
                    value};

endmodule

`default_nettype wire

// ===== rtl/pmsc_checker.sv =====
// Port-level checks on the result channel of the point-mass safety controller.
// Depends on pmsc_pkg; bound to point_mass_safety_controller below.
`default_nettype none

module pmsc_checker
  import pmsc_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // A stalled result stays put until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or vanished while stalled");

  // Nothing comes out in the cycle after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // The position gradient of the first axis is always +1 or -1.
  a_gpos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[81:80] == GPOS_POS) || (m_tdata[81:80] == GPOS_NEG))
    else $error("position gradient is not a unit sign");

  // The priority never exceeds one.
  a_prio: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[198:182] <= PRIO_ONE)
    else $error("priority above one");

endmodule

bind point_mass_safety_controller pmsc_checker u_pmsc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
